FILE: hdl/uqe_pkg.sv
// Shared types, codes and character constants for the URL query encoder.
// No dependencies; every other file of the block imports this package.
package uqe_pkg;

	// Width of the capacity register and of the output character counter.
	localparam int unsigned CAP_W = 13;

	// Largest buffer capacity honored; larger register values act as this.
	localparam logic [CAP_W-1:0] CAPACITY_MAX = 13'd4096;

	// Reset value of the capacity register.
	localparam logic [CAP_W-1:0] CAPACITY_RESET = 13'd256;

	// Input item kinds.
	localparam logic KIND_TEXT = 1'b0;
	localparam logic KIND_END  = 1'b1;

	// Character constants.
	localparam logic [7:0] CH_PLUS        = 8'h2B;
	localparam logic [7:0] CH_PERCENT     = 8'h25;
	localparam logic [7:0] CH_SPACE       = 8'h20;
	localparam logic [7:0] CH_NUL         = 8'h00;
	localparam logic [7:0] UTF8_LEAD      = 8'hC0;
	localparam logic [7:0] UTF8_CONT      = 8'h80;
	localparam logic [7:0] UTF8_CONT_MASK = 8'h3F;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_CHAR     = 2'd0,
		ST_OK       = 2'd1,
		ST_OVERFLOW = 2'd2,
		ST_EMPTY    = 2'd3
	} status_t;

	// Work handed from the front part to the back part.
	typedef enum logic [1:0] {
		JOB_SINGLE  = 2'd0,   // one literal character in data
		JOB_TRIPLET = 2'd1,   // one %XX triplet of data
		JOB_UTF8    = 2'd2,   // two %XX triplets for a Latin-1 byte in data
		JOB_STATUS  = 2'd3    // end-of-text status code in data[1:0]
	} job_kind_t;

	typedef struct packed {
		job_kind_t  kind;
		logic [7:0] data;
	} job_t;

	// Uppercase hex digit for one nibble.
	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		logic [7:0] ch;
		if (nib < 4'd10) begin
			ch = 8'h30 + {4'd0, nib};
		end else begin
			ch = 8'h37 + {4'd0, nib};
		end
		return ch;
	endfunction

endpackage

FILE: hdl/uqe_front.sv
// Front part of the URL query encoder: accepts items, classifies bytes and
// keeps the character count, overflow flag and capacity register. Uses uqe_pkg.
module uqe_front import uqe_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cap_wr_en,
	input  logic [CAP_W-1:0] cap_wr_data,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             in_kind,
	input  logic [7:0]       in_byte,
	input  logic             queue_full,
	output logic             push,
	output job_t             push_job
);

	logic [CAP_W-1:0] capacity_q;
	logic [CAP_W-1:0] count_q;
	logic             overflow_q;

	logic [CAP_W-1:0] cap_eff;
	logic [2:0]       need_len;
	logic [CAP_W:0]   sum;
	logic             fits;
	logic             accept;
	job_t             char_job;
	status_t          end_status;

	// Bytes that pass through unchanged.
	function automatic logic passes_through(input logic [7:0] b);
		return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A) ||
		       (b >= 8'h30 && b <= 8'h39) || b == 8'h2D || b == 8'h5F ||
		       b == 8'h2E || b == 8'h7E;
	endfunction

	// Classify the byte and size its encoding.
	always_comb begin
		if (passes_through(in_byte)) begin
			char_job = '{kind: JOB_SINGLE, data: in_byte};
			need_len = 3'd1;
		end else if (in_byte == CH_SPACE) begin
			char_job = '{kind: JOB_SINGLE, data: CH_PLUS};
			need_len = 3'd1;
		end else if (in_byte[7]) begin
			char_job = '{kind: JOB_UTF8, data: in_byte};
			need_len = 3'd6;
		end else begin
			char_job = '{kind: JOB_TRIPLET, data: in_byte};
			need_len = 3'd3;
		end
	end

	// Fit check: the encoding plus the terminator must fit the buffer.
	assign cap_eff = (capacity_q > CAPACITY_MAX) ? CAPACITY_MAX : capacity_q;
	assign sum     = {1'b0, count_q} + {{(CAP_W-2){1'b0}}, need_len};
	assign fits    = sum < {1'b0, cap_eff};

	// End-of-text outcome.
	always_comb begin
		if (overflow_q) begin
			end_status = ST_OVERFLOW;
		end else if (count_q == '0) begin
			end_status = ST_EMPTY;
		end else begin
			end_status = ST_OK;
		end
	end

	// A transaction is taken whenever the queue has room.
	assign in_ready = !queue_full;
	assign accept   = in_valid && in_ready;
	assign push     = accept && (in_kind == KIND_END || (!overflow_q && fits));
	assign push_job = (in_kind == KIND_END) ?
	                  job_t'{kind: JOB_STATUS, data: {6'd0, end_status}} : char_job;

	// Capacity register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAPACITY_RESET;
		end else if (cap_wr_en) begin
			capacity_q <= cap_wr_data;
		end
	end

	// Character count and sticky overflow flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			overflow_q <= 1'b0;
		end else if (accept) begin
			if (in_kind == KIND_END) begin
				count_q    <= '0;
				overflow_q <= 1'b0;
			end else if (!overflow_q) begin
				if (fits) begin
					count_q <= sum[CAP_W-1:0];
				end else begin
					overflow_q <= 1'b1;
				end
			end
		end
	end

	// End of text leaves a clean state for the next text.
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_kind == KIND_END) |=> (count_q == '0 && !overflow_q))
		else $error("state not cleared after end of text");

	// Nothing but a status job is queued once overflow has been seen.
	a_no_chars_after_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(overflow_q && push) |-> (push_job.kind == JOB_STATUS))
		else $error("character job queued after overflow");

endmodule

FILE: hdl/uqe_fifo.sv
// Short job queue between the front and back parts of the URL query encoder.
// Register storage with a combinational head read. Uses uqe_pkg for job_t.
module uqe_fifo import uqe_pkg::*; #(
	parameter int unsigned DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output logic head_valid,
	output job_t head_job
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	job_t            slot_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [AW:0]     count_q;

	assign full       = (count_q == (AW+1)'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_job   = slot_q[rd_ptr_q];

	// Storage write.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	// Pointers and fill count; DEPTH is a power of two so pointers wrap.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full && !pop))
		else $error("job queue overrun");

	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("job queue underrun");

endmodule

FILE: hdl/uqe_back.sv
// Back part of the URL query encoder: expands queued jobs into output characters, one per
// cycle while jobs are queued and the output is not stalled, through an output register. Uses uqe_pkg.
module uqe_back import uqe_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       head_valid,
	input  job_t       head_job,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_char,
	output status_t    out_status,
	output logic       out_last
);

	logic [2:0] step_q;
	logic       valid_s1;
	logic [7:0] char_s1;
	status_t    status_s1;
	logic       last_s1;

	logic [2:0] last_step;
	logic       second_half;
	logic [1:0] pos;
	logic [7:0] value;
	logic [7:0] char_d;
	logic       load;

	// Position inside the job's character sequence.
	always_comb begin
		case (head_job.kind)
			JOB_TRIPLET: last_step = 3'd2;
			JOB_UTF8:    last_step = 3'd5;
			default:     last_step = 3'd0;
		endcase
	end

	assign second_half = (step_q >= 3'd3);
	assign pos         = second_half ? 2'(step_q - 3'd3) : step_q[1:0];

	// Byte being escaped: for a UTF-8 job the lead byte, then the continuation byte; else the job's data byte.
	always_comb begin
		if (head_job.kind == JOB_UTF8) begin
			value = second_half ? (UTF8_CONT | (head_job.data & UTF8_CONT_MASK))
			                    : (UTF8_LEAD | {6'd0, head_job.data[7:6]});
		end else begin
			value = head_job.data;
		end
	end

	// Character for the current step.
	always_comb begin
		case (head_job.kind)
			JOB_SINGLE: char_d = head_job.data;
			JOB_STATUS: char_d = CH_NUL;
			default: begin
				case (pos)
					2'd0:    char_d = CH_PERCENT;
					2'd1:    char_d = hex_char(value[7:4]);
					default: char_d = hex_char(value[3:0]);
				endcase
			end
		endcase
	end

	// Load the output register when it is empty or being drained.
	assign load = head_valid && (!valid_s1 || out_ready);
	assign pop  = load && (step_q == last_step);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			step_q   <= '0;
		end else begin
			if (load) begin
				valid_s1 <= 1'b1;
				step_q   <= pop ? 3'd0 : step_q + 3'd1;
			end else if (out_ready) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (load) begin
			char_s1   <= char_d;
			status_s1 <= (head_job.kind == JOB_STATUS) ? status_t'(head_job.data[1:0])
			                                           : ST_CHAR;
			last_s1   <= (step_q == last_step);
		end
	end

	assign out_valid  = valid_s1;
	assign out_char   = char_s1;
	assign out_status = status_s1;
	assign out_last   = last_s1;

	// A status result always closes its run and carries no character.
	a_status_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && status_s1 != ST_CHAR) |-> (last_s1 && char_s1 == CH_NUL))
		else $error("status result malformed");

	// The step counter never runs past the job at the head of the queue.
	a_step_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> (step_q <= last_step))
		else $error("step counter beyond job length");

endmodule

FILE: hdl/url_query_percent_encoder_top.sv
// After an input transaction is accepted, its job is written into the job queue and then
// loaded into the back part's output register. Results leave at one per cycle while jobs
// are queued and m_tready is high; a byte gives one character (letter, digit, mark or
// space), one %XX triplet (ASCII) or two (Latin-1); end of text gives one status result.
// Reset clears the count, overflow flag, job queue and output register and
// sets the capacity to 256.
// Top level of the URL query encoder: front, job queue and back part.
// Depends on uqe_pkg, uqe_front, uqe_fifo and uqe_back.
module url_query_percent_encoder_top import uqe_pkg::*; #(
	parameter int unsigned FIFO_DEPTH = 4   // power of two, 2 or more
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [CAP_W-1:0] cfg_wr_data,   // buffer_capacity
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [7:0]       s_tdata,       // [7:0] char_byte
	input  logic             s_tuser,       // [0] kind
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [7:0]       m_tdata,       // [7:0] out_char
	output logic [1:0]       m_tuser,       // [1:0] status
	output logic             m_tlast        // last_of_run
);

	logic    push;
	job_t    push_job;
	logic    queue_full;
	logic    pop;
	logic    head_valid;
	job_t    head_job;
	status_t out_status;

	// Front part: classification, fit check and text state.
	uqe_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cap_wr_en   (cfg_wr_en),
		.cap_wr_data (cfg_wr_data),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.in_kind     (s_tuser),
		.in_byte     (s_tdata),
		.queue_full  (queue_full),
		.push        (push),
		.push_job    (push_job)
	);

	// Job queue decoupling the two parts.
	uqe_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.full       (queue_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	// Back part: character expansion and output register.
	uqe_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_job   (head_job),
		.pop        (pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_char   (m_tdata),
		.out_status (out_status),
		.out_last   (m_tlast)
	);

	assign m_tuser = out_status;

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench for url_query_percent_encoder_top: streams text bytes and
// end-of-text items, predicts the encoded characters and checks every result transaction.
// Depends on uqe_pkg and the encoder RTL only.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import uqe_pkg::*;

	localparam int RANDOM_ITEMS = 450;
	localparam int IDLE_LIMIT   = 1000;
	localparam int SETTLE       = 16;
	localparam int PRINT_CAP    = 200;
	localparam logic [127:0] HEX_DIGITS = "0123456789ABCDEF";

	typedef struct {
		logic       kind;
		logic [7:0] char_byte;
	} text_item_t;

	typedef struct {
		logic [7:0] ch;
		status_t    status;
		logic       last;
	} query_char_t;

	logic             clk         = 1'b0;
	logic             arst_n      = 1'b0;
	logic             cfg_wr_en   = 1'b0;
	logic [CAP_W-1:0] cfg_wr_data = '0;
	logic             s_tvalid    = 1'b0;
	logic             s_tready;
	logic [7:0]       s_tdata     = '0;
	logic             s_tuser     = KIND_TEXT;
	logic             m_tvalid;
	logic             m_tready    = 1'b1;
	logic [7:0]       m_tdata;
	logic [1:0]       m_tuser;
	logic             m_tlast;

	// Pending input transactions and the characters they are expected to produce.
	text_item_t  text_q[$];
	query_char_t expected_chars[$];

	// Encoder state as predicted by the testbench.
	logic [CAP_W-1:0] cap_model = CAPACITY_RESET;
	int               char_count = 0;
	bit               overflow_flag = 1'b0;

	int live_items     = 0;
	int mismatch_count = 0;
	int send_gap_max   = 0;
	int recv_gap_max   = 0;
	int send_wait      = 0;
	int recv_wait      = 0;
	int idle_cycles    = 0;

	url_query_percent_encoder_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.m_tlast     (m_tlast)
	);

	// 50 MHz clock.
	always #10 clk = ~clk;

	task automatic flag_mismatch(input string msg);
		if (mismatch_count < PRINT_CAP) begin
			$display("[%0t] MISMATCH: %s", $realtime, msg);
		end
		mismatch_count++;
	endtask

	// Letters, digits and the four unreserved marks pass through as they are.
	function automatic bit is_unreserved(input logic [7:0] b);
		return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z") ||
			(b >= "0" && b <= "9") || b == "-" || b == "_" || b == "." || b == "~";
	endfunction

	// Percent escape of one byte, first character in the top bits.
	function automatic logic [23:0] pct_triplet(input logic [7:0] v);
		int hi;
		int lo;
		hi = int'(v[7:4]);
		lo = int'(v[3:0]);
		return {CH_PERCENT, HEX_DIGITS[8*(15-hi) +: 8], HEX_DIGITS[8*(15-lo) +: 8]};
	endfunction

	// Works out the characters one accepted input causes and updates the predicted state.
	function automatic void predict_query_chars(input logic kind, input logic [7:0] b);
		logic [47:0] seq;
		int          n;
		int          limit;
		status_t     st;
		limit = (cap_model > CAPACITY_MAX) ? int'(CAPACITY_MAX) : int'(cap_model);
		live_items++;
		if (kind == KIND_END) begin
			if (overflow_flag) begin
				st = ST_OVERFLOW;
			end else if (char_count == 0) begin
				st = ST_EMPTY;
			end else begin
				st = ST_OK;
			end
			expected_chars.push_back('{ch: CH_NUL, status: st, last: 1'b1});
			char_count = 0;
			overflow_flag = 1'b0;
		end else if (!overflow_flag) begin
			seq = '0;
			if (is_unreserved(b)) begin
				seq[7:0] = b;
				n = 1;
			end else if (b == CH_SPACE) begin
				seq[7:0] = CH_PLUS;
				n = 1;
			end else if (b >= 8'h80) begin
				seq = {pct_triplet(UTF8_LEAD | (b >> 6)),
					pct_triplet(UTF8_CONT | (b & UTF8_CONT_MASK))};
				n = 6;
			end else begin
				seq[23:0] = pct_triplet(b);
				n = 3;
			end
			// The whole encoding plus the terminator has to fit, else nothing is sent.
			if (char_count + n >= limit) begin
				overflow_flag = 1'b1;
			end else begin
				for (int k = 0; k < n; k++) begin
					expected_chars.push_back('{ch: seq[8*(n-1-k) +: 8], status: ST_CHAR,
						last: (k == n - 1)});
				end
				char_count += n;
			end
		end
	endfunction

	// Input driver: predicts on acceptance, then idles or presents the next transaction.
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			send_wait = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				predict_query_chars(s_tuser, s_tdata);
				send_wait = $urandom_range(0, send_gap_max);
			end
			if (!(s_tvalid && !s_tready)) begin
				if (send_wait > 0) begin
					send_wait--;
					s_tvalid <= 1'b0;
				end else if (text_q.size() > 0) begin
					text_item_t it;
					it = text_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= it.char_byte;
					s_tuser <= it.kind;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Output monitor: checks each result against the oldest expectation.
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b1;
			recv_wait = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_chars.size() == 0) begin
					flag_mismatch($sformatf("unexpected result: char %02h status %0d last %0b",
						m_tdata, m_tuser, m_tlast));
				end else begin
					query_char_t want;
					want = expected_chars.pop_front();
					if (m_tdata !== want.ch) begin
						flag_mismatch($sformatf("out_char %02h, expected %02h", m_tdata, want.ch));
					end
					if (m_tuser !== want.status) begin
						flag_mismatch($sformatf("status %0d, expected %s", m_tuser,
							want.status.name()));
					end
					if (m_tlast !== want.last) begin
						flag_mismatch($sformatf("last_of_run %0b, expected %0b", m_tlast, want.last));
					end
				end
				recv_wait = $urandom_range(0, recv_gap_max);
			end
			if (recv_wait > 0) begin
				recv_wait--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Watchdog on cycles with no transaction on either side.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("url_query_percent_encoder_top regression: fail");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	task automatic queue_item(input logic kind, input logic [7:0] b);
		text_q.push_back('{kind: kind, char_byte: b});
	endtask

	// Waits until every transaction is sent and answered, then lets the pipeline empty.
	task automatic settle_idle();
		while (text_q.size() != 0 || s_tvalid || expected_chars.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_capacity(input logic [CAP_W-1:0] v);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		cap_model = v;
	endtask

	// Random text byte weighted toward each encoding class.
	function automatic logic [7:0] random_text_byte();
		int r;
		int pick;
		logic [7:0] b;
		pick = $urandom_range(0, 9);
		if (pick <= 3) begin
			r = $urandom_range(0, 65);
			if (r < 26) begin
				b = 8'("A" + r);
			end else if (r < 52) begin
				b = 8'("a" + r - 26);
			end else if (r < 62) begin
				b = 8'("0" + r - 52);
			end else begin
				case (r)
					62: b = "-";
					63: b = "_";
					64: b = ".";
					default: b = "~";
				endcase
			end
		end else if (pick == 4) begin
			b = CH_SPACE;
		end else if (pick <= 6) begin
			b = 8'($urandom_range(8'h80, 8'hFF));
		end else if (pick <= 8) begin
			b = 8'($urandom_range(0, 8'h7F));
		end else begin
			b = 8'($urandom);
		end
		return b;
	endfunction

	initial begin
		int base;
		int texts;
		int len;
		logic [CAP_W-1:0] cap_pick;
		logic [7:0] edge_bytes[16];

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset capacity: empty text, then every encoding class and the byte extremes.
		edge_bytes = '{"A", "z", "0", "9", "-", "_", ".", "~", CH_SPACE, CH_NUL,
			8'h7F, 8'h80, 8'hFF, "/", "@", "{"};
		queue_item(KIND_END, 8'h00);
		foreach (edge_bytes[i]) queue_item(KIND_TEXT, edge_bytes[i]);
		queue_item(KIND_END, 8'hA5);
		settle_idle();

		// Smallest legal capacity: one character fits, the next overflows and sticks.
		set_capacity(13'd2);
		queue_item(KIND_TEXT, "a");
		queue_item(KIND_TEXT, "b");
		queue_item(KIND_TEXT, "c");
		queue_item(KIND_END, 8'hFF);
		settle_idle();

		// Capacity below two: any byte overflows, an empty text is still reported empty.
		set_capacity(13'd0);
		queue_item(KIND_TEXT, "a");
		queue_item(KIND_END, 8'h00);
		queue_item(KIND_END, 8'h00);
		settle_idle();

		// Random texts over a spread of capacities and idling patterns.
		base = live_items;
		while (live_items - base < RANDOM_ITEMS) begin
			case ($urandom_range(0, 9))
				0: cap_pick = 13'($urandom_range(0, 1));
				1: cap_pick = 13'd2;
				2: cap_pick = 13'($urandom_range(3, 8));
				3, 4: cap_pick = 13'($urandom_range(9, 40));
				5, 6: cap_pick = 13'($urandom_range(41, 120));
				7: cap_pick = CAPACITY_RESET;
				8: cap_pick = CAPACITY_MAX;
				default: cap_pick = 13'($urandom_range(4097, 8191));
			endcase
			set_capacity(cap_pick);
			send_gap_max = $urandom_range(0, 1) * 4;
			recv_gap_max = $urandom_range(0, 1) * 4;
			texts = $urandom_range(3, 8);
			repeat (texts) begin
				len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
				repeat (len) queue_item(KIND_TEXT, random_text_byte());
				queue_item(KIND_END, 8'($urandom));
			end
			settle_idle();
		end

		if (expected_chars.size() != 0) begin
			flag_mismatch($sformatf("%0d expected results never arrived", expected_chars.size()));
		end
		if (mismatch_count == 0) begin
			$display("url_query_percent_encoder_top regression: pass");
		end else begin
			$display("url_query_percent_encoder_top regression: fail");
		end
		$finish;
	end

endmodule
